[src/smt_pkg.sv]
package smt_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned SizeW       = 7;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRemove = 1'b1;

  localparam logic [StatusW-1:0] StDone     = 2'd0;
  localparam logic [StatusW-1:0] StFull     = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;

  typedef struct packed {
    logic                     func;
    logic signed [ValueW-1:0] value;
  } smt_in_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [SizeW-1:0]         size;
    logic signed [ValueW-1:0] smallest;
    logic                     empty_res;
  } smt_out_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     en;
    logic                     ins;
    logic                     found;
    logic signed [ValueW-1:0] value;
  } smt_cmd_t;

endpackage

[src/smt_cell.sv]
module smt_cell
  import smt_pkg::*;
(
  input  logic                     clk_i,
  input  smt_cmd_t                 cmd_i,
  input  logic                     occupied_i,
  input  logic                     prev_ge_i,
  input  logic signed [ValueW-1:0] prev_entry_i,
  input  logic signed [ValueW-1:0] next_entry_i,
  output logic                     ge_o,
  output logic                     eq_o,
  output logic signed [ValueW-1:0] entry_o,
  output logic signed [ValueW-1:0] entry_next_o
);

  logic signed [ValueW-1:0] entry_q, entry_d;

  always_comb begin
    // insert: at or past the slot where the value goes
    // remove: at or past the first entry not below the value
    if (cmd_i.ins) begin
      ge_o = !occupied_i || (entry_q > cmd_i.value);
    end else begin
      ge_o = occupied_i && (entry_q >= cmd_i.value);
    end
    eq_o = occupied_i && (entry_q == cmd_i.value);

    entry_d = entry_q;
    if (cmd_i.en && ge_o) begin
      if (cmd_i.ins) begin
        entry_d = prev_ge_i ? prev_entry_i : cmd_i.value;
      end else if (cmd_i.found) begin
        entry_d = next_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule

[src/sorted_multiset_table.sv]
// an accepted word's result word is registered and shows in the next cycle
// throughput: one word per cycle unless stalled; each cell of the row compares
//   the broadcast value and shifts its entry to a neighbour in the same cycle
// reset: occupancy and the output valid clear at once; entry contents stay
//   undefined and are only read below the occupancy
module sorted_multiset_table
  import smt_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  smt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output smt_out_t out_data_o
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);

  logic [OccW-1:0] occ_q, occ_d;
  logic            out_valid_q;
  smt_out_t        out_data_q, out_data_d;
  logic            accept;
  smt_cmd_t        cmd;
  logic            full;

  logic [CAPACITY-1:0]      ge, eq, occupied;
  logic signed [ValueW-1:0] entry [CAPACITY];
  logic signed [ValueW-1:0] entry_next [CAPACITY];
  logic [SizeW-1:0]         size_field;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (occ_q == OccW'(CAPACITY));

  always_comb begin
    cmd.ins   = (in_data_i.func == FuncInsert);
    cmd.value = in_data_i.value;
    cmd.found = |eq;
    cmd.en    = accept && (cmd.ins ? !full : cmd.found);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     prev_ge;
    logic signed [ValueW-1:0] prev_entry, next_entry;

    assign occupied[i] = (OccW'(i) < occ_q);

    if (i == 0) begin : g_first
      assign prev_ge    = 1'b0;
      assign prev_entry = entry[0];
    end else begin : g_mid
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_inner
      assign next_entry = entry[i+1];
    end

    smt_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occupied[i]),
      .prev_ge_i   (prev_ge),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .ge_o        (ge[i]),
      .eq_o        (eq[i]),
      .entry_o     (entry[i]),
      .entry_next_o(entry_next[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (cmd.en) begin
      occ_d = cmd.ins ? occ_q + OccW'(1) : occ_q - OccW'(1);
    end
  end

  // size field wraps when the occupancy is wider than it
  if (OccW >= SizeW) begin : g_size_trunc
    assign size_field = occ_d[SizeW-1:0];
  end else begin : g_size_ext
    assign size_field = {{(SizeW - OccW){1'b0}}, occ_d};
  end

  always_comb begin
    if (cmd.ins) begin
      out_data_d.status = full ? StFull : StDone;
    end else begin
      out_data_d.status = cmd.found ? StDone : StNotFound;
    end
    out_data_d.size      = size_field;
    out_data_d.empty_res = (occ_d == '0);
    out_data_d.smallest  = (occ_d == '0) ? '0 : entry_next[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (!in_stall_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[src/smt_checker.sv]
module smt_checker
  import smt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input smt_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input smt_out_t out_data_o
);

  // a held result word keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // every accepted word yields a result word in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word gave no result");

  // an empty store reports zero size and a zero smallest value
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.empty_res |->
      out_data_o.size == '0 && out_data_o.smallest == '0)
    else $error("empty result with contents");

  // a dropped insert means the store holds values
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StFull |-> !out_data_o.empty_res)
    else $error("full status on an empty store");

  // no status code beyond the defined ones
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == StDone || out_data_o.status == StFull ||
      out_data_o.status == StNotFound)
    else $error("undefined status code");

endmodule

bind sorted_multiset_table smt_checker u_smt_checker (.*);

[tb/tb_top.sv]
module tb_top;
  import smt_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int unsigned RandWords = 1080;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  smt_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  smt_out_t out_data_o;

  // no gaps and no stalls while set
  bit calm;

  class multiset_mirror;
    logic signed [ValueW-1:0] shadow[$];
    smt_out_t                 due[$];
    int unsigned              errors;
    int unsigned              n_ins, n_rem, n_full, n_missing, peak, n_checked;

    // updates the mirrored store and queues the word the block should answer with
    function void apply_op(smt_in_t w);
      logic signed [ValueW-1:0] v;
      smt_out_t                 res;
      int                       pos;
      v = w.value;
      pos = 0;
      res.status = StDone;
      if (w.func == FuncInsert) begin
        n_ins++;
        if (shadow.size() >= Cap) begin
          res.status = StFull;
          n_full++;
        end else begin
          // lands after every equal value
          while (pos < shadow.size() && shadow[pos] <= v) pos++;
          shadow.insert(pos, v);
        end
      end else begin
        n_rem++;
        while (pos < shadow.size() && shadow[pos] < v) pos++;
        if (pos >= shadow.size() || shadow[pos] != v) begin
          res.status = StNotFound;
          n_missing++;
        end else begin
          shadow.delete(pos);
        end
      end
      if (shadow.size() > peak) peak = shadow.size();
      res.size      = SizeW'(shadow.size());
      res.smallest  = (shadow.size() > 0) ? shadow[0] : '0;
      res.empty_res = (shadow.size() == 0);
      due.push_back(res);
    endfunction

    function void check_reply(smt_out_t got);
      smt_out_t exp;
      n_checked++;
      if (due.size() == 0) begin
        $error("result word with nothing outstanding: %p", got);
        errors++;
        return;
      end
      exp = due.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.size !== exp.size) begin
        $error("size: expected %0d, got %0d", exp.size, got.size);
        errors++;
      end
      if (got.smallest !== exp.smallest) begin
        $error("smallest: expected %0d, got %0d", exp.smallest, got.smallest);
        errors++;
      end
      if (got.empty_res !== exp.empty_res) begin
        $error("empty_res: expected %0d, got %0d", exp.empty_res, got.empty_res);
        errors++;
      end
    endfunction
  endclass

  multiset_mirror mirror = new;

  sorted_multiset_table #(
    .CAPACITY(Cap)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) mirror.check_reply(out_data_o);
    out_stall_i <= !calm && ($urandom_range(99) < 37);
  end

  task automatic send_word(input logic func, input logic signed [ValueW-1:0] v);
    smt_in_t w;
    w.func  = func;
    w.value = v;
    while (!calm && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    mirror.apply_op(w);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(99);
    if (r < 40) begin
      // narrow band so duplicates pile up
      v = int'($urandom_range(15)) - 8;
    end else if (r < 60) begin
      case ($urandom_range(3))
        0:       v = 32'h8000_0000;
        1:       v = 32'h7fff_ffff;
        2:       v = -1;
        default: v = 0;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_present();
    if (mirror.shadow.size() == 0) return pick_value();
    return mirror.shadow[$urandom_range(mirror.shadow.size() - 1)];
  endfunction

  initial begin
    int unsigned sent;
    int unsigned mode;
    int unsigned run_len;
    logic        func;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners
    send_word(FuncRemove, 5);               // empty store
    send_word(FuncInsert, 0);
    send_word(FuncRemove, 0);               // last value leaves
    send_word(FuncInsert, 32'h7fff_ffff);
    send_word(FuncInsert, 32'h8000_0000);
    send_word(FuncInsert, 0);
    send_word(FuncInsert, 0);
    send_word(FuncInsert, -1);
    send_word(FuncInsert, 32'haaaa_aaaa);
    send_word(FuncInsert, 32'h5555_5555);
    send_word(FuncRemove, 1);               // absent, between neighbours
    send_word(FuncRemove, 0);               // first of a pair
    send_word(FuncRemove, 32'h8000_0000);
    send_word(FuncRemove, 32'h7fff_ffff);
    send_word(FuncRemove, 32'haaaa_aaaa);
    send_word(FuncRemove, 32'h5555_5555);
    send_word(FuncRemove, -1);
    send_word(FuncRemove, 0);
    send_word(FuncRemove, 0);               // empty again

    // random: fill, drain and mixed runs
    sent = 0;
    while (sent < RandWords) begin
      mode    = $urandom_range(2);
      run_len = $urandom_range(40, 120);
      for (int unsigned k = 0; k < run_len && sent < RandWords; k++) begin
        calm = (sent >= 350 && sent < 550);
        case (mode)
          0:       func = ($urandom_range(99) < 85) ? FuncInsert : FuncRemove;
          1:       func = ($urandom_range(99) < 85) ? FuncRemove : FuncInsert;
          default: func = 1'($urandom_range(1));
        endcase
        if (func == FuncInsert) send_word(FuncInsert, pick_value());
        else if ($urandom_range(99) < 70) send_word(FuncRemove, pick_present());
        else send_word(FuncRemove, pick_value());
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;

    while (mirror.due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d inserts and %0d removes, %0d against a full store,",
             mirror.n_ins, mirror.n_rem, mirror.n_full);
    $display("%0d of absent values, peak occupancy %0d, %0d result words checked",
             mirror.n_missing, mirror.peak, mirror.n_checked);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result words outstanding", mirror.due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
